// File: rtl/core/arm_pkg.sv
// Package for the modem response matcher: codes, configuration and state types.
`timescale 1ns / 1ps
package arm_pkg;

    localparam int PROMPT_CHARS     = 8;
    localparam int TERMINATOR_CHARS = 16;
    localparam int RESPONSE_MAX     = 32;

    localparam logic [7:0] CHAR_CR = 8'h0D;

    // configuration register indexes
    localparam logic [2:0] REG_PROMPT_TEXT   = 3'd0;
    localparam logic [2:0] REG_PROMPT_LENGTH = 3'd1;
    localparam logic [2:0] REG_TERM_LOW      = 3'd2;
    localparam logic [2:0] REG_TERM_HIGH     = 3'd3;
    localparam logic [2:0] REG_TERM_LENGTH   = 3'd4;
    localparam logic [2:0] REG_CAPACITY      = 3'd5;
    localparam logic [2:0] REG_TIMEOUT       = 3'd6;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_START = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_WAIT    = 2'd0,
        ST_TERM    = 2'd1,
        ST_TIMEOUT = 2'd2,
        ST_IDLE    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PH_PROMPT  = 2'd0,
        PH_GATHER  = 2'd1,
        PH_TERM    = 2'd2,
        PH_NOPROMPT = 2'd3
    } t_phase;

    typedef struct packed {
        logic [63:0] prompt_text;
        logic [3:0]  prompt_length;
        logic [63:0] term_low;
        logic [63:0] term_high;
        logic [4:0]  term_length;
        logic [5:0]  capacity;
        logic [7:0]  timeout;
    } t_cfg;

    typedef struct packed {
        logic       waiting;
        t_phase     phase;
        logic [3:0] prompt_pos;
        logic [4:0] term_pos;
        logic [5:0] room_left;
        logic [4:0] stored_count;
        logic [7:0] elapsed;
    } t_state;

    typedef struct packed {
        t_status    status;
        logic       captured_valid;
        logic [7:0] captured_char;
        logic [4:0] captured_count;
        logic       prompt_found;
    } t_result;

endpackage

// File: rtl/core/arm_step.sv
// Next-state and result logic for one item of the response matcher.
`timescale 1ns / 1ps
module arm_step (
    input  arm_pkg::t_cfg    i_cfg,
    input  arm_pkg::t_state  i_state,
    input  arm_pkg::t_op     i_op,
    input  logic [7:0]       i_byte,
    output arm_pkg::t_state  o_state,
    output arm_pkg::t_result o_result
);
    import arm_pkg::*;

    logic [3:0]   plen;
    logic [4:0]   tlen;
    logic [5:0]   cap;
    logic [127:0] term_text;
    logic [7:0]   p_char;
    logic [7:0]   t_char;
    logic [3:0]   p_pos_inc;
    logic [4:0]   t_pos_inc;
    logic [7:0]   elapsed_inc;

    always_comb begin
        plen = (i_cfg.prompt_length > 4'(PROMPT_CHARS)) ? 4'(PROMPT_CHARS) : i_cfg.prompt_length;
        if (i_cfg.term_length == 5'd0) begin
            tlen = 5'd1;
        end else if (i_cfg.term_length > 5'(TERMINATOR_CHARS)) begin
            tlen = 5'(TERMINATOR_CHARS);
        end else begin
            tlen = i_cfg.term_length;
        end
        cap = (i_cfg.capacity > 6'(RESPONSE_MAX)) ? 6'(RESPONSE_MAX) : i_cfg.capacity;
    end

    assign term_text   = {i_cfg.term_high, i_cfg.term_low};
    assign p_char      = i_cfg.prompt_text[{i_state.prompt_pos[2:0], 3'b000} +: 8];
    assign t_char      = term_text[{i_state.term_pos[3:0], 3'b000} +: 8];
    assign p_pos_inc   = i_state.prompt_pos + 4'd1;
    assign t_pos_inc   = i_state.term_pos + 5'd1;
    assign elapsed_inc = i_state.elapsed + 8'd1;

    always_comb begin
        o_state = i_state;
        o_result.status         = i_state.waiting ? ST_WAIT : ST_IDLE;
        o_result.captured_valid = 1'b0;
        o_result.captured_char  = 8'd0;

        case (i_op)
            OP_START: begin
                o_state.waiting      = 1'b1;
                o_state.phase        = (plen != 4'd0) ? PH_PROMPT : PH_NOPROMPT;
                o_state.prompt_pos   = 4'd0;
                o_state.term_pos     = 5'd0;
                o_state.room_left    = cap;
                o_state.stored_count = 5'd0;
                o_state.elapsed      = 8'd0;
                o_result.status      = ST_WAIT;
            end
            OP_TICK: begin
                if (i_state.waiting) begin
                    o_state.elapsed = elapsed_inc;
                    if (elapsed_inc >= i_cfg.timeout) begin
                        o_state.waiting = 1'b0;
                        o_result.status = ST_TIMEOUT;
                    end
                end
            end
            OP_BYTE: begin
                if (i_state.waiting) begin
                    if (plen != 4'd0) begin
                        if (i_state.phase == PH_PROMPT) begin
                            if (i_byte == p_char) begin
                                o_state.prompt_pos = p_pos_inc;
                                if (p_pos_inc >= plen) begin
                                    o_state.phase = PH_GATHER;
                                end
                            end else begin
                                o_state.prompt_pos =
                                    (i_byte == i_cfg.prompt_text[7:0]) ? 4'd1 : 4'd0;
                            end
                        end else if (i_state.phase == PH_GATHER
                                     && i_state.room_left != 6'd0) begin
                            // the closing byte (CR or full buffer) is not stored
                            if (i_byte == CHAR_CR || i_state.room_left < 6'd2) begin
                                o_state.phase = PH_TERM;
                            end else begin
                                o_result.captured_valid = 1'b1;
                                o_result.captured_char  = i_byte;
                                o_state.room_left       = i_state.room_left - 6'd1;
                                o_state.stored_count    = i_state.stored_count + 5'd1;
                            end
                        end
                    end
                    if (i_byte == t_char) begin
                        o_state.term_pos = t_pos_inc;
                        if (t_pos_inc >= tlen) begin
                            o_state.waiting = 1'b0;
                            o_result.status = ST_TERM;
                        end
                    end else begin
                        o_state.term_pos = (i_byte == i_cfg.term_low[7:0]) ? 5'd1 : 5'd0;
                    end
                end
            end
            default: begin
            end
        endcase

        o_result.captured_count = o_state.stored_count;
        o_result.prompt_found   = (o_state.phase == PH_GATHER) || (o_state.phase == PH_TERM);
    end

endmodule

// File: rtl/core/at_response_matcher_core.sv
// Top level of the modem response matcher: configuration, state and result register.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | i_in_valid / o_in_ready, i_operation,     | in
//          | i_rx_byte                                 |
//  result  | o_out_valid / i_out_ready, o_status,      | out
//          | o_captured_valid/char/count,o_prompt_found|
//  config  | i_cfg_we, i_cfg_index, i_cfg_data         | in
//
// One item per cycle while the input is ready; its result is in the result register
// in the cycle after it is accepted, set by a single pass through the step logic.
// Synchronous active-low reset restores register defaults and an idle matcher.
// The input is taken whenever the result register is empty or being drained in
// the same cycle, so a stalled result holds off only the next item.
`timescale 1ns / 1ps
module at_response_matcher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic        o_captured_valid,
    output logic [7:0]  o_captured_char,
    output logic [4:0]  o_captured_count,
    output logic        o_prompt_found,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import arm_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;
    logic    r_out_valid;
    logic    in_fire;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    arm_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_op     (t_op'(i_operation)),
        .i_byte   (i_rx_byte),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prompt_text   <= 64'd0;
            r_cfg.prompt_length <= 4'd0;
            r_cfg.term_low      <= 64'h0000_0000_0A0D_4B4F;
            r_cfg.term_high     <= 64'd0;
            r_cfg.term_length   <= 5'd4;
            r_cfg.capacity      <= 6'd0;
            r_cfg.timeout       <= 8'd30;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PROMPT_TEXT:   r_cfg.prompt_text   <= i_cfg_data;
                REG_PROMPT_LENGTH: r_cfg.prompt_length <= i_cfg_data[3:0];
                REG_TERM_LOW:      r_cfg.term_low      <= i_cfg_data;
                REG_TERM_HIGH:     r_cfg.term_high     <= i_cfg_data;
                REG_TERM_LENGTH:   r_cfg.term_length   <= i_cfg_data[4:0];
                REG_CAPACITY:      r_cfg.capacity      <= i_cfg_data[5:0];
                REG_TIMEOUT:       r_cfg.timeout       <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_result.status;
    assign o_captured_valid = r_result.captured_valid;
    assign o_captured_char  = r_result.captured_char;
    assign o_captured_count = r_result.captured_count;
    assign o_prompt_found   = r_result.prompt_found;

    // a start always reports waiting in the next result
    a_start_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_operation == OP_START) |=> (o_out_valid && o_status == ST_WAIT))
        else $error("start item did not report waiting");

    // a wait ends only with a terminator or a timeout result
    a_wait_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(r_state.waiting)) |->
            (o_status == ST_TERM || o_status == ST_TIMEOUT))
        else $error("wait ended without terminator or timeout");

    // captures happen only during an active wait
    a_capture_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_captured_valid) |-> (o_status != ST_IDLE))
        else $error("capture reported while idle");

    // stored characters imply the prompt was found
    a_count_prompt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_captured_count != 5'd0) |-> o_prompt_found)
        else $error("characters stored without prompt");

endmodule
